[design/assert_macros.svh]
// Assertion macros used by the timer table top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer table assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer table assertion failed");

`endif

[design/ott_pkg.sv]
// Package: types, constants and sizes for the one-shot timer table.
`timescale 1ns / 1ps
package ott_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic OP_SCHEDULE = 1'b0;
  localparam logic OP_TICK     = 1'b1;

  localparam logic [1:0] KIND_STATUS    = 2'd0;
  localparam logic [1:0] KIND_FIRED     = 2'd1;
  localparam logic [1:0] KIND_IDLE_TICK = 2'd2;

  localparam logic [1:0] ST_UPDATED  = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_REJECTED = 2'd3;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  task_id;
    logic [15:0] delay_ticks;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] status;
    logic [7:0] fired_task;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [15:0] remaining;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic walk;
    logic finish;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_done;
  } stat_t;

endpackage

[design/one_shot_timer_table_top.sv]
// Top level of the one-shot timer table.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// One-shot timer table: TABLE_ENTRIES timers, each a task identifier and a
// remaining tick count, held in a small RAM. A transaction is taken when start
// is high and busy is low. A schedule transaction (opcode 0) updates the
// lowest timer already holding the task, or loads the highest free timer, and
// gives one status result; task 0 is rejected and a zero delay cancels. A
// tick transaction (opcode 1) counts every running timer down by one and
// reports each timer that expires, in index order, or one "nothing fired"
// result. In every transaction the walk reads one timer per cycle through
// the single RAM read port, and a final step settles the schedule write or
// the final tick result. Results appear on result for exactly one cycle,
// marked by strobe; the receiver cannot stall them, so it must take every
// strobed transaction. The final result of each transaction carries last,
// and is shown in the first cycle with busy low.
module one_shot_timer_table_top import ott_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output result_t result,
  output logic    strobe
);

  cmd_t  cmd;
  stat_t stat;

  ott_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  ott_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .stat   (stat),
    .result (result),
    .strobe (strobe)
  );

  // an accepted transaction always occupies the block
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  // finishing a walk always produces the closing result
  `ASSERT_NEXT(a_finish_strobe, clk, rst, cmd.finish, strobe && result.last)
  // intermediate results only while the walk is still running
  `ASSERT_IMPLY(a_mid_busy, clk, rst, strobe && !result.last, busy)
  // an expiring timer never reports the idle task
  `ASSERT_IMPLY(a_fired_task, clk, rst, strobe && (result.kind == KIND_FIRED),
                result.fired_task != 8'd0)

endmodule

[design/ott_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ott_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/ott_ctrl.sv]
// Controller state machine for the timer table.
`timescale 1ns / 1ps
module ott_ctrl import ott_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  logic state;
  logic state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.load = start;
        if (start) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.scan_done) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

[design/ott_dp.sv]
// Datapath: timer RAM, entry walk, match/free search and result register.
`timescale 1ns / 1ps
module ott_dp import ott_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    cmd,
  input  item_t   item,
  output stat_t   stat,
  output result_t result,
  output logic    strobe
);

  item_t              req;
  logic [CNT_W-1:0]   idx;
  logic               rd_vld;
  logic [IDX_W-1:0]   rd_idx;
  logic [TABLE_ENTRIES-1:0] valid;
  logic               match_found;
  logic [IDX_W-1:0]   match_idx;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic               pend_vld;
  logic [7:0]         pend_task;

  logic [ENTRY_W-1:0] rdata;
  entry_t             ent;
  logic               proc;
  logic               re;
  logic [IDX_W-1:0]   raddr;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  entry_t             wdata;
  logic               fire;
  logic               strobe_next;
  result_t            result_next;

  ott_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // never-written entries read as empty
  assign ent   = valid[rd_idx] ? entry_t'(rdata) : '0;
  assign proc  = cmd.walk && rd_vld;
  assign re    = cmd.walk && (idx < CNT_W'(TABLE_ENTRIES));
  assign raddr = idx[IDX_W-1:0];
  assign fire  = proc && (req.opcode == OP_TICK) && (ent.remaining == 16'd1);
  assign stat.scan_done = (idx == CNT_W'(TABLE_ENTRIES)) && !rd_vld;

  always_comb begin
    we          = 1'b0;
    waddr       = rd_idx;
    wdata       = '0;
    strobe_next = 1'b0;
    result_next = '0;
    if (proc && (req.opcode == OP_TICK) && (ent.remaining != 16'd0)) begin
      we = 1'b1;
      if (ent.remaining != 16'd1) begin
        wdata.task_id   = ent.task_id;
        wdata.remaining = ent.remaining - 16'd1;
      end
    end
    // a fired task is held back one step so the final one can carry last
    if (fire && pend_vld) begin
      strobe_next            = 1'b1;
      result_next.kind       = KIND_FIRED;
      result_next.fired_task = pend_task;
    end
    if (cmd.finish) begin
      strobe_next      = 1'b1;
      result_next.last = 1'b1;
      if (req.opcode == OP_TICK) begin
        if (pend_vld) begin
          result_next.kind       = KIND_FIRED;
          result_next.fired_task = pend_task;
        end else begin
          result_next.kind = KIND_IDLE_TICK;
        end
      end else begin
        result_next.kind = KIND_STATUS;
        if (req.task_id == 8'd0) begin
          result_next.status = ST_REJECTED;
        end else if (req.delay_ticks == 16'd0) begin
          result_next.status = ST_REJECTED;
          we    = match_found;
          waddr = match_idx;
        end else if (match_found) begin
          result_next.status = ST_UPDATED;
          we              = 1'b1;
          waddr           = match_idx;
          wdata.task_id   = req.task_id;
          wdata.remaining = req.delay_ticks;
        end else if (free_found) begin
          result_next.status = ST_INSERTED;
          we              = 1'b1;
          waddr           = free_idx;
          wdata.task_id   = req.task_id;
          wdata.remaining = req.delay_ticks;
        end else begin
          result_next.status = ST_FULL;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      idx         <= '0;
      rd_vld      <= 1'b0;
      valid       <= '0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      pend_vld    <= 1'b0;
      strobe      <= 1'b0;
    end else begin
      strobe <= strobe_next;
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (cmd.load) begin
        idx         <= '0;
        rd_vld      <= 1'b0;
        match_found <= 1'b0;
        free_found  <= 1'b0;
        pend_vld    <= 1'b0;
      end else if (cmd.walk) begin
        rd_vld <= re;
        if (re) begin
          idx <= idx + CNT_W'(1);
        end
        if (proc && (req.opcode == OP_SCHEDULE)) begin
          if ((ent.remaining != 16'd0) && (ent.task_id == req.task_id)) begin
            match_found <= 1'b1;
          end else if (ent.remaining == 16'd0) begin
            free_found <= 1'b1;
          end
        end
        if (fire) begin
          pend_vld <= 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    result <= result_next;
    if (cmd.load) begin
      req <= item;
    end
    if (cmd.walk && re) begin
      rd_idx <= raddr;
    end
    if (proc && (req.opcode == OP_SCHEDULE)) begin
      // lowest-index match, highest-index free entry
      if ((ent.remaining != 16'd0) && (ent.task_id == req.task_id)) begin
        if (!match_found) begin
          match_idx <= rd_idx;
        end
      end else if (ent.remaining == 16'd0) begin
        free_idx <= rd_idx;
      end
    end
    if (fire) begin
      pend_task <= ent.task_id;
    end
  end

endmodule
